@@ design/sdal_pkg.sv @@
// Shared types, character codes and the divide-by-ten helper for the decimal line printer.
package sdal_pkg;

	localparam int unsigned VAL_W   = 16;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned DIG_W   = 4;
	localparam int unsigned MAX_DIG = 5;
	localparam int unsigned DIX_W   = $clog2(MAX_DIG);
	localparam int unsigned QDEPTH  = 2;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

	// x / 10 == (x * 0xCCCD) >> 19, exact for every 16-bit x
	localparam logic [VAL_W-1:0] RECIP10 = 16'hCCCD;
	localparam int unsigned      RSHIFT  = 19;

	typedef struct packed {
		logic             neg;
		logic [VAL_W-1:0] mag;
	} item_t;

	function automatic logic [VAL_W-1:0] div10(input logic [VAL_W-1:0] x);
		logic [2*VAL_W-1:0] prod;
		prod = {{VAL_W{1'b0}}, x} * {{VAL_W{1'b0}}, RECIP10};
		return {{RSHIFT-VAL_W{1'b0}}, prod[2*VAL_W-1:RSHIFT]};
	endfunction

endpackage

@@ design/sdal_front.sv @@
// Front end: takes requests, splits sign and magnitude, and queues them for the back end.
module sdal_front
	import sdal_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             num_valid,
	output logic             num_stall,
	input  logic [VAL_W-1:0] value,
	output logic             item_valid,
	output item_t            item,
	input  logic             item_pop
);

	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	item_t            ent_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	item_t            incoming;

	assign num_stall  = (count_q == CNT_W'(QDEPTH));
	assign push       = num_valid && !num_stall;
	assign item_valid = (count_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = ent_q[rd_ptr_q];

	assign incoming.neg = value[VAL_W-1];
	assign incoming.mag = value[VAL_W-1] ? (~value + VAL_W'(1)) : value;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/sdal_back.sv @@
// Back end: peels decimal digits one per cycle, then streams the line through an output register.
module sdal_back
	import sdal_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  item_t             item,
	output logic              item_pop,
	output logic              chr_valid,
	input  logic              chr_stall,
	output logic [CHAR_W-1:0] char_code,
	output logic              last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef enum logic [3:0] {
		PH_SIGN  = 4'b0001,
		PH_DIGIT = 4'b0010,
		PH_CR    = 4'b0100,
		PH_LF    = 4'b1000
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic              neg_q;
	logic [VAL_W-1:0]  mag_q;
	logic [DIX_W-1:0]  cnt_q;
	logic [DIG_W-1:0]  dig_q [MAX_DIG];
	logic              chr_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic [VAL_W-1:0]  quot;
	logic [VAL_W-1:0]  quot_x10;
	logic [VAL_W-1:0]  rem_full;
	logic              conv_done;
	logic              out_free;

	assign quot      = div10(mag_q);
	assign quot_x10  = (quot << 3) + (quot << 1);
	assign rem_full  = mag_q - quot_x10;
	assign conv_done = (quot == '0) || (cnt_q == DIX_W'(MAX_DIG - 1));
	assign out_free  = !chr_valid_q || !chr_stall;
	assign item_pop  = (state_q == ST_IDLE);

	assign chr_valid = chr_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CONV) begin
			dig_q[cnt_q] <= rem_full[DIG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SIGN;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			cnt_q       <= '0;
			chr_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			// a free output register takes a new byte exactly when emitting
			if (out_free) begin
				chr_valid_q <= (state_q == ST_EMIT);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						neg_q   <= item.neg;
						mag_q   <= item.mag;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					mag_q <= quot;
					if (conv_done) begin
						phase_q <= neg_q ? PH_SIGN : PH_DIGIT;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + DIX_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						last_q <= 1'b0;
						unique case (phase_q)
							PH_SIGN: begin
								char_q  <= CH_MINUS;
								phase_q <= PH_DIGIT;
							end
							PH_DIGIT: begin
								char_q <= CH_ZERO + {{CHAR_W-DIG_W{1'b0}}, dig_q[cnt_q]};
								if (cnt_q == '0) begin
									phase_q <= PH_CR;
								end else begin
									cnt_q <= cnt_q - DIX_W'(1);
								end
							end
							PH_CR: begin
								char_q  <= CH_CR;
								phase_q <= PH_LF;
							end
							PH_LF: begin
								char_q  <= CH_LF;
								last_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
							default: phase_q <= PH_SIGN;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/signed_to_decimal_ascii_line_top.sv @@
// Top level of the signed decimal line printer: front queue plus digit and byte back end.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  number   | num_valid / num_stall  | value (16b signed)
//  line     | chr_valid / chr_stall  | char_code (8b), last (1b)
//
// A request is loaded into the back end from the queue; the divide-by-ten unit then
// yields one digit per cycle, and the line leaves one byte per cycle through the single
// output register while the sink does not stall.
// A two-entry queue takes requests until full while the back end works or the sink stalls.
// Reset empties the queue and the output register; nothing else needs clearing.
module signed_to_decimal_ascii_line_top
	import sdal_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              num_valid,
	output logic              num_stall,
	input  logic [VAL_W-1:0]  value,
	output logic              chr_valid,
	input  logic              chr_stall,
	output logic [CHAR_W-1:0] char_code,
	output logic              last
);

	logic  item_valid;
	item_t item;
	logic  item_pop;

	sdal_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_valid  (num_valid),
		.num_stall  (num_stall),
		.value      (value),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	sdal_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.chr_valid  (chr_valid),
		.chr_stall  (chr_stall),
		.char_code  (char_code),
		.last       (last)
	);

endmodule

@@ design/sdal_check.sv @@
// Port-level checks for the decimal line printer, bound to the top level.
module sdal_check
	import sdal_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              chr_valid,
	input logic              chr_stall,
	input logic [CHAR_W-1:0] char_code,
	input logic              last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_stall |=> chr_valid && $stable(char_code) && $stable(last))
		else $error("stalled line byte changed");

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && last |-> char_code == CH_LF)
		else $error("last flag on a byte other than LF");

	a_lf_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && char_code == CH_LF |-> last)
		else $error("LF without last flag");

	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && !chr_stall && char_code == CH_CR |=> chr_valid && char_code == CH_LF)
		else $error("CR not followed at once by LF");

endmodule

bind signed_to_decimal_ascii_line_top sdal_check u_sdal_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.chr_valid (chr_valid),
	.chr_stall (chr_stall),
	.char_code (char_code),
	.last      (last)
);
